>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge.
`define ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/isrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isrf_pkg
// Shared types and codes of the source address range filter.
// ----------------------------------------------------------------------------
package isrf_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic        valid;
        logic [31:0] first;
        logic [31:0] last;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic clr_step;
        logic scan_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic done;
    } sts_t;

endpackage
`default_nettype wire

>>> hdl/ip_source_range_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// A lookup scan stops at the first hit and an add scan at the first free entry.
// A new word is taken only once the result of the last one is loaded, as the
// single read port of the range table is scanned one entry per cycle.
// Reset: after rst_n releases, a clearing pass empties every table entry while
// req_stall stays high.
// ----------------------------------------------------------------------------
// ip_source_range_filter
// Whitelist of source address ranges with lookup, add and remove operations.
// ----------------------------------------------------------------------------

module ip_source_range_filter #(
    parameter int MAX_RANGES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] src_addr,
    input  wire logic [31:0] range_first,
    input  wire logic [31:0] range_last,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic             verdict,
    output logic             status
);

    isrf_pkg::cmd_t cmd;
    isrf_pkg::sts_t sts;

    isrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    isrf_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .src_addr    (src_addr),
        .range_first (range_first),
        .range_last  (range_last),
        .verdict     (verdict),
        .status      (status)
    );

endmodule
`default_nettype wire

>>> hdl/isrf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isrf_dp
// Range table memory, scan counter, range compare and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isrf_dp #(
    parameter int MAX_RANGES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire isrf_pkg::cmd_t cmd,
    output isrf_pkg::sts_t      sts,
    input  wire logic [1:0]     func,
    input  wire logic [31:0]    src_addr,
    input  wire logic [31:0]    range_first,
    input  wire logic [31:0]    range_last,
    output logic                verdict,
    output logic                status
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_RANGES);
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_RANGES - 1);

    isrf_pkg::entry_t mem [MAX_RANGES];
    isrf_pkg::entry_t rd_data_reg;

    logic [1:0]    op_reg;
    logic [31:0]   src_reg;
    logic [31:0]   first_reg;
    logic [31:0]   last_reg;
    logic          verdict_reg;
    logic          status_reg;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          chk_reg, chk_next;
    logic [AW-1:0] chk_addr_reg;
    logic          found_reg, found_next;

    logic             issue;
    logic             eval;
    logic             hit;
    logic             rm_match;
    logic             we;
    logic [AW-1:0]    waddr;
    isrf_pkg::entry_t wdata;

    // A read is issued for every entry until the table end or a decisive entry.
    assign issue = cmd.scan_step && (cnt_reg < CNT_MAX) && !found_reg;
    assign eval  = cmd.scan_step && chk_reg && !found_reg;

    always_comb
    begin
        hit = rd_data_reg.valid && (src_reg >= rd_data_reg.first)
              && (src_reg <= rd_data_reg.last);
        rm_match = rd_data_reg.valid && (rd_data_reg.first == first_reg)
                   && (rd_data_reg.last == last_reg);
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = chk_addr_reg;
        wdata = rd_data_reg;
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = cnt_reg[AW-1:0];
            wdata = '0;
        end
        else if (eval && (op_reg == isrf_pkg::OP_ADD) && !rd_data_reg.valid)
        begin
            we          = 1'b1;
            wdata.valid = 1'b1;
            wdata.first = first_reg;
            wdata.last  = last_reg;
        end
        else if (eval && (op_reg == isrf_pkg::OP_REMOVE) && rm_match)
        begin
            we          = 1'b1;
            wdata.valid = 1'b0;
        end
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        chk_next   = issue;
        found_next = found_reg;
        if (cmd.start)
        begin
            cnt_next   = '0;
            chk_next   = 1'b0;
            found_next = 1'b0;
        end
        else
        begin
            if (cmd.clr_step || issue)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            if (eval && (((op_reg == isrf_pkg::OP_LOOKUP) && hit)
                         || ((op_reg == isrf_pkg::OP_ADD) && !rd_data_reg.valid)))
            begin
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            chk_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            chk_reg   <= chk_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (issue)
        begin
            rd_data_reg <= mem[cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        chk_addr_reg <= cnt_reg[AW-1:0];
        if (cmd.start)
        begin
            op_reg    <= func;
            src_reg   <= src_addr;
            first_reg <= range_first;
            last_reg  <= range_last;
        end
        if (cmd.out_load)
        begin
            verdict_reg <= (op_reg == isrf_pkg::OP_LOOKUP) && found_reg;
            status_reg  <= (op_reg == isrf_pkg::OP_ADD) && !found_reg;
        end
    end

    assign sts.clr_last = (cnt_reg == CNT_LAST);
    assign sts.done     = found_reg || (op_reg == isrf_pkg::OP_NONE)
                          || ((cnt_reg == CNT_MAX) && !chk_reg);

    assign verdict = verdict_reg;
    assign status  = status_reg;

    `ASSERT_AT(a_cnt_bound, cnt_reg <= CNT_MAX, "scan counter ran past the table end")
    `ASSERT_IMP(a_found_op, found_reg, op_reg == isrf_pkg::OP_LOOKUP || op_reg == isrf_pkg::OP_ADD, "found flag set for an operation that stops on nothing")
    `ASSERT_IMP(a_write_src, we, cmd.clr_step || cmd.scan_step, "table written outside clearing or scanning")

endmodule
`default_nettype wire

>>> hdl/isrf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isrf_ctrl
// Sequencer for the clearing pass, the table scan and the result handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isrf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output isrf_pkg::cmd_t      cmd,
    input  wire isrf_pkg::sts_t sts
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_free;

    // The result slot can take a new word when empty or being drained now.
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    `ASSERT_IMP(a_rsp_from_finish, $rose(rsp_valid_reg), $past(state_reg == ST_FINISH), "result word appeared without a finished scan")
    `ASSERT_NXT(a_no_reclear, state_reg != ST_CLEAR, state_reg != ST_CLEAR, "clearing pass restarted outside reset")

endmodule
`default_nettype wire
